### rtl/pid_thrust_controller_core_macros.svh
// ----------------------------------------------------------------------------
// pid thrust controller assertion macros
// shared property forms for the controller rtl
// ----------------------------------------------------------------------------
`ifndef PID_THRUST_CONTROLLER_CORE_MACROS_SVH
`define PID_THRUST_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define PTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// types, constants and microcode store of the pid thrust controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptc_pkg;

	localparam int TARGET_W = 32;
	localparam int GAIN_W   = 32;
	localparam int SENS_W   = 16;
	localparam int INTEG_W  = 48;
	localparam int FRAC_W   = 16;
	localparam int THRUST_W = 18;
	localparam int PDATA_W  = 32;
	localparam int PADDR_W  = 5;
	localparam int REGIDX_W = 3;

	typedef logic [REGIDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_TARGET      = 3'd0;
	localparam reg_idx_t REG_GAIN_PROP   = 3'd1;
	localparam reg_idx_t REG_GAIN_INTEG  = 3'd2;
	localparam reg_idx_t REG_GAIN_DERIV  = 3'd3;
	localparam reg_idx_t REG_SENSITIVITY = 3'd4;

	localparam logic [TARGET_W-1:0] RST_TARGET      = 32'd0;
	localparam logic [GAIN_W-1:0]   RST_GAIN_PROP   = 32'd58982;
	localparam logic [GAIN_W-1:0]   RST_GAIN_INTEG  = 32'd0;
	localparam logic [GAIN_W-1:0]   RST_GAIN_DERIV  = 32'd65536;
	localparam logic [SENS_W-1:0]   RST_SENSITIVITY = 16'd1000;

	typedef struct packed {
		logic [TARGET_W-1:0] target_speed;
		logic [GAIN_W-1:0]   gain_prop;
		logic [GAIN_W-1:0]   gain_integ;
		logic [GAIN_W-1:0]   gain_deriv;
		logic [SENS_W-1:0]   sensitivity;
	} cfg_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_IDLE     = 4'd0;
	localparam pc_t PC_INTEG    = 4'd1;
	localparam pc_t PC_MUL_P_LO = 4'd2;
	localparam pc_t PC_MUL_P_HI = 4'd3;
	localparam pc_t PC_MUL_I_LO = 4'd4;
	localparam pc_t PC_MUL_I_HI = 4'd5;
	localparam pc_t PC_MUL_D_LO = 4'd6;
	localparam pc_t PC_MUL_D_HI = 4'd7;
	localparam pc_t PC_ACC_TAIL = 4'd8;
	localparam pc_t PC_CHECK    = 4'd9;
	localparam pc_t PC_DIV      = 4'd10;
	localparam pc_t PC_OUT      = 4'd11;

	typedef enum logic [1:0] {
		OP_PROP,
		OP_INTEG,
		OP_DERIV
	} opsel_t;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_HOLD_IN,
		JMP_EARLY,
		JMP_LOOP,
		JMP_HOLD_OUT,
		JMP_GOTO
	} jump_t;

	typedef struct packed {
		logic   wait_in;
		logic   integ_en;
		logic   acc_clr;
		logic   mul_en;
		opsel_t op_sel;
		logic   hi_half;
		logic   acc_en;
		logic   check_en;
		logic   div_en;
		logic   out_en;
		jump_t  jump;
		pc_t    target;
	} ucode_t;

	typedef struct packed {
		logic   accept;
		logic   integ_en;
		logic   acc_clr;
		logic   mul_en;
		opsel_t op_sel;
		logic   hi_half;
		logic   acc_en;
		logic   check_en;
		logic   div_en;
		logic   out_load;
	} ctrl_t;

	typedef struct packed {
		logic early;
		logic div_last;
		logic out_busy;
	} stat_t;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t uc;
		uc = '0;
		uc.jump = JMP_NEXT;
		unique case (pc)
			PC_IDLE: begin
				uc.wait_in = 1'b1;
				uc.jump    = JMP_HOLD_IN;
			end
			PC_INTEG: begin
				uc.integ_en = 1'b1;
				uc.acc_clr  = 1'b1;
			end
			PC_MUL_P_LO: begin
				uc.mul_en = 1'b1;
				uc.op_sel = OP_PROP;
			end
			PC_MUL_P_HI: begin
				uc.mul_en  = 1'b1;
				uc.op_sel  = OP_PROP;
				uc.hi_half = 1'b1;
				uc.acc_en  = 1'b1;
			end
			PC_MUL_I_LO: begin
				uc.mul_en = 1'b1;
				uc.op_sel = OP_INTEG;
				uc.acc_en = 1'b1;
			end
			PC_MUL_I_HI: begin
				uc.mul_en  = 1'b1;
				uc.op_sel  = OP_INTEG;
				uc.hi_half = 1'b1;
				uc.acc_en  = 1'b1;
			end
			PC_MUL_D_LO: begin
				uc.mul_en = 1'b1;
				uc.op_sel = OP_DERIV;
				uc.acc_en = 1'b1;
			end
			PC_MUL_D_HI: begin
				uc.mul_en  = 1'b1;
				uc.op_sel  = OP_DERIV;
				uc.hi_half = 1'b1;
				uc.acc_en  = 1'b1;
			end
			PC_ACC_TAIL: begin
				uc.acc_en = 1'b1;
			end
			PC_CHECK: begin
				uc.check_en = 1'b1;
				uc.jump     = JMP_EARLY;
				uc.target   = PC_OUT;
			end
			PC_DIV: begin
				uc.div_en = 1'b1;
				uc.jump   = JMP_LOOP;
				uc.target = PC_DIV;
			end
			PC_OUT: begin
				uc.out_en = 1'b1;
				uc.jump   = JMP_HOLD_OUT;
				uc.target = PC_IDLE;
			end
			default: begin
				uc.jump   = JMP_GOTO;
				uc.target = PC_IDLE;
			end
		endcase
		return uc;
	endfunction

endpackage

### rtl/ptc_speed_if.sv
// ----------------------------------------------------------------------------
// ptc_speed_if
// speed sample channel, valid/ready with one measured speed per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptc_speed_if #(
	parameter int SPEED_BITS = 32
) ();

	logic                  valid;
	logic                  ready;
	logic [SPEED_BITS-1:0] measured_speed;

	modport source (output valid, output measured_speed, input ready);
	modport sink (input valid, input measured_speed, output ready);

endinterface

### rtl/ptc_thrust_if.sv
// ----------------------------------------------------------------------------
// ptc_thrust_if
// thrust result channel, valid/ready with thrust command and clamp flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptc_thrust_if import ptc_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [THRUST_W-1:0] thrust_cmd;
	logic                clamped;

	modport source (output valid, output thrust_cmd, output clamped, input ready);
	modport sink (input valid, input thrust_cmd, input clamped, output ready);

endinterface

### rtl/ptc_apb_regs.sv
// ----------------------------------------------------------------------------
// ptc_apb_regs
// apb register bank: setpoint, three pid gains and output sensitivity
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_apb_regs import ptc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx   = paddr[PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed <= RST_TARGET;
			cfg_q.gain_prop    <= RST_GAIN_PROP;
			cfg_q.gain_integ   <= RST_GAIN_INTEG;
			cfg_q.gain_deriv   <= RST_GAIN_DERIV;
			cfg_q.sensitivity  <= RST_SENSITIVITY;
		end else if (wr_en) begin
			unique case (idx)
				REG_TARGET:      cfg_q.target_speed <= pwdata[TARGET_W-1:0];
				REG_GAIN_PROP:   cfg_q.gain_prop    <= pwdata[GAIN_W-1:0];
				REG_GAIN_INTEG:  cfg_q.gain_integ   <= pwdata[GAIN_W-1:0];
				REG_GAIN_DERIV:  cfg_q.gain_deriv   <= pwdata[GAIN_W-1:0];
				REG_SENSITIVITY: cfg_q.sensitivity  <= pwdata[SENS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET:      prdata = PDATA_W'(cfg_q.target_speed);
			REG_GAIN_PROP:   prdata = PDATA_W'(cfg_q.gain_prop);
			REG_GAIN_INTEG:  prdata = PDATA_W'(cfg_q.gain_integ);
			REG_GAIN_DERIV:  prdata = PDATA_W'(cfg_q.gain_deriv);
			REG_SENSITIVITY: prdata = PDATA_W'(cfg_q.sensitivity);
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### rtl/ptc_sequencer.sv
// ----------------------------------------------------------------------------
// ptc_sequencer
// step counter and microcode store; issues one control word per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_sequencer import ptc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output ctrl_t ctrl
);

	pc_t    pc_q;
	pc_t    pc_d;
	pc_t    pc_inc;
	ucode_t uc;

	assign uc     = ucode_rom(pc_q);
	assign pc_inc = pc_q + 1'b1;

	always_comb begin
		unique case (uc.jump)
			JMP_NEXT:     pc_d = pc_inc;
			JMP_HOLD_IN:  pc_d = in_valid ? pc_inc : pc_q;
			JMP_EARLY:    pc_d = stat.early ? uc.target : pc_inc;
			JMP_LOOP:     pc_d = stat.div_last ? pc_inc : uc.target;
			JMP_HOLD_OUT: pc_d = stat.out_busy ? pc_q : uc.target;
			JMP_GOTO:     pc_d = uc.target;
			default:      pc_d = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		in_ready      = uc.wait_in;
		ctrl.accept   = uc.wait_in && in_valid;
		ctrl.integ_en = uc.integ_en;
		ctrl.acc_clr  = uc.acc_clr;
		ctrl.mul_en   = uc.mul_en;
		ctrl.op_sel   = uc.op_sel;
		ctrl.hi_half  = uc.hi_half;
		ctrl.acc_en   = uc.acc_en;
		ctrl.check_en = uc.check_en;
		ctrl.div_en   = uc.div_en;
		ctrl.out_load = uc.out_en && !stat.out_busy;
	end

endmodule

### rtl/ptc_datapath.sv
// ----------------------------------------------------------------------------
// ptc_datapath
// error and integral state, shared multiplier, accumulator, serial divider
// and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_datapath import ptc_pkg::*; #(
	parameter int SPEED_BITS   = 32,
	parameter int THRUST_LIMIT = 242000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic [SPEED_BITS-1:0] speed,
	input  ctrl_t                 ctrl,
	output stat_t                 stat,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [THRUST_W-1:0]   thrust_cmd,
	output logic                  clamped
);

	localparam int ERR_W  = ((SPEED_BITS > TARGET_W) ? SPEED_BITS : TARGET_W) + 1;
	localparam int SUMI_W = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
	localparam int DER_W  = ERR_W + 1;
	localparam int OPD_W  = (DER_W > INTEG_W) ? DER_W : INTEG_W;
	localparam int HALF_W = (OPD_W + 1) / 2;
	localparam int PROD_W = GAIN_W + HALF_W;
	localparam int ACC_W  = GAIN_W + OPD_W + 2;
	localparam int SH_W   = ACC_W - FRAC_W;
	localparam int TOP_W  = SH_W - $clog2(THRUST_LIMIT + 1);
	localparam int Q_W    = $clog2(THRUST_LIMIT + 1);
	localparam int CNT_W  = $clog2(Q_W + 1);
	localparam int RES_W  = (Q_W > THRUST_W) ? Q_W : THRUST_W;

	localparam logic signed [INTEG_W-1:0] IMAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] IMIN = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam logic [Q_W-1:0]            LIMIT_Q = Q_W'(THRUST_LIMIT);

	// loop state and per-item operands
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   last_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [DER_W-1:0]   deriv_q;

	logic signed [ERR_W-1:0]   err_c;
	logic signed [SUMI_W-1:0]  integ_sum;
	logic                      integ_fits;
	logic signed [INTEG_W-1:0] integ_sat;
	logic signed [DER_W-1:0]   deriv_c;

	// multiplier
	logic signed [OPD_W-1:0]   op_x;
	logic [GAIN_W-1:0]         gain;
	logic [GAIN_W-1:0]         g_mag;
	logic [OPD_W-1:0]          x_mag;
	logic [HALF_W-1:0]         x_half;
	logic [PROD_W-1:0]         prod_c;
	logic [PROD_W-1:0]         prod_s1;
	logic                      neg_s1;
	logic                      hi_s1;
	logic [ACC_W-1:0]          term_c;
	logic [ACC_W-1:0]          acc_q;

	// range check and divider
	logic [SH_W-1:0]           sh_c;
	logic                      sum_neg;
	logic [SENS_W-1:0]         div_c;
	logic signed [SH_W:0]      negsum;
	logic                      neg_clamp;
	logic [TOP_W-1:0]          top_c;
	logic                      ovf_c;
	logic                      early_q;
	logic                      res_clamp_q;
	logic [Q_W-1:0]            res_thrust_q;
	logic [SENS_W-1:0]         rem_q;
	logic [Q_W-1:0]            quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SENS_W:0]           rem_ext;
	logic [SENS_W:0]           rem_sub;
	logic                      qbit;

	// result
	logic                      q_ovf;
	logic [Q_W-1:0]            fin_thrust;
	logic                      fin_clamp;
	logic [RES_W-1:0]          fin_wide;
	logic                      out_valid_q;
	logic [THRUST_W-1:0]       thrust_q;
	logic                      clamped_q;

	assign err_c = ERR_W'($signed({1'b0, cfg.target_speed})) - ERR_W'($signed({1'b0, speed}));

	assign integ_sum  = SUMI_W'(integ_q) + SUMI_W'(err_q);
	assign integ_fits = (integ_sum[SUMI_W-1:INTEG_W-1] == '0) ||
	                    (integ_sum[SUMI_W-1:INTEG_W-1] == '1);
	assign integ_sat  = integ_fits ? integ_sum[INTEG_W-1:0] :
	                    (integ_sum[SUMI_W-1] ? IMIN : IMAX);
	assign deriv_c    = DER_W'(err_q) - DER_W'(last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (ctrl.integ_en) begin
			integ_q <= integ_sat;
			last_q  <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			err_q <= err_c;
		end
		if (ctrl.integ_en) begin
			deriv_q <= deriv_c;
		end
	end

	always_comb begin
		unique case (ctrl.op_sel)
			OP_PROP: begin
				op_x = OPD_W'(err_q);
				gain = cfg.gain_prop;
			end
			OP_INTEG: begin
				op_x = OPD_W'(integ_q);
				gain = cfg.gain_integ;
			end
			OP_DERIV: begin
				op_x = OPD_W'(deriv_q);
				gain = cfg.gain_deriv;
			end
			default: begin
				op_x = '0;
				gain = '0;
			end
		endcase
	end

	// sign-magnitude product, operand taken in two halves
	assign g_mag  = gain[GAIN_W-1] ? (~gain + 1'b1) : gain;
	assign x_mag  = op_x[OPD_W-1] ? (~op_x + 1'b1) : op_x;
	assign x_half = ctrl.hi_half ? HALF_W'(x_mag >> HALF_W) : x_mag[HALF_W-1:0];
	assign prod_c = g_mag * x_half;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= prod_c;
			neg_s1  <= gain[GAIN_W-1] ^ op_x[OPD_W-1];
			hi_s1   <= ctrl.hi_half;
		end
	end

	assign term_c = hi_s1 ? (ACC_W'(prod_s1) << HALF_W) : ACC_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= neg_s1 ? (acc_q - term_c) : (acc_q + term_c);
		end
	end

	// floor shift, sign and early overflow check
	assign sh_c      = acc_q[ACC_W-1:FRAC_W];
	assign sum_neg   = sh_c[SH_W-1];
	assign div_c     = (cfg.sensitivity == '0) ? SENS_W'(1) : cfg.sensitivity;
	assign negsum    = (SH_W+1)'($signed(sh_c)) + (SH_W+1)'($signed({1'b0, div_c}));
	assign neg_clamp = negsum[SH_W] || (negsum == '0);
	assign top_c     = sh_c[SH_W-1:Q_W];
	assign ovf_c     = top_c >= TOP_W'(div_c);

	assign rem_ext = {rem_q, quo_q[Q_W-1]};
	assign rem_sub = rem_ext - (SENS_W+1)'(div_c);
	assign qbit    = rem_ext >= (SENS_W+1)'(div_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_q <= 1'b0;
			cnt_q   <= '0;
		end else if (ctrl.check_en) begin
			early_q <= sum_neg || ovf_c;
			cnt_q   <= CNT_W'(Q_W);
		end else if (ctrl.div_en) begin
			cnt_q   <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.check_en) begin
			res_clamp_q  <= sum_neg ? neg_clamp : 1'b1;
			res_thrust_q <= sum_neg ? '0 : LIMIT_Q;
			rem_q        <= top_c[SENS_W-1:0];
			quo_q        <= sh_c[Q_W-1:0];
		end else if (ctrl.div_en) begin
			rem_q <= qbit ? rem_sub[SENS_W-1:0] : rem_ext[SENS_W-1:0];
			quo_q <= (quo_q << 1) | Q_W'(qbit);
		end
	end

	assign stat.early    = ctrl.check_en && (sum_neg || ovf_c);
	assign stat.div_last = (cnt_q == CNT_W'(1));
	assign stat.out_busy = out_valid_q && !out_ready;

	assign q_ovf      = quo_q > LIMIT_Q;
	assign fin_thrust = early_q ? res_thrust_q : (q_ovf ? LIMIT_Q : quo_q);
	assign fin_clamp  = early_q ? res_clamp_q : q_ovf;
	assign fin_wide   = RES_W'(fin_thrust);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			thrust_q  <= fin_wide[THRUST_W-1:0];
			clamped_q <= fin_clamp;
		end
	end

	assign out_valid  = out_valid_q;
	assign thrust_cmd = thrust_q;
	assign clamped    = clamped_q;

endmodule

### rtl/pid_thrust_controller_core.sv
// ----------------------------------------------------------------------------
// pid_thrust_controller_core
// pid speed loop with q16.16 gains, sensitivity divide and thrust clamp
// ----------------------------------------------------------------------------
// One speed sample in gives one thrust request out. A sample runs from
// acceptance to the result register through the microcode program: six
// passes through one shared 32 x 24 bit multiplier and a restoring divider
// that yields one quotient bit per cycle, Q bits in all, where Q is the bit
// width of THRUST_LIMIT. The divider is skipped when the shifted pid sum is
// negative or certainly above the limit.
// A new sample is taken once the previous one has reached the result register,
// even while that result still waits to be taken downstream.
`timescale 1ns / 1ps
`include "pid_thrust_controller_core_macros.svh"

module pid_thrust_controller_core import ptc_pkg::*; #(
	parameter int SPEED_BITS   = 32,
	parameter int THRUST_LIMIT = 242000
) (
	input  logic               clk,
	input  logic               arst_n,
	ptc_speed_if.sink          sample,
	ptc_thrust_if.source       thrust,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t  cfg;
	ctrl_t ctrl;
	stat_t stat;

	assign pready = 1'b1;

	ptc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ptc_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ptc_datapath #(
		.SPEED_BITS   (SPEED_BITS),
		.THRUST_LIMIT (THRUST_LIMIT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.speed      (sample.measured_speed),
		.ctrl       (ctrl),
		.stat       (stat),
		.out_ready  (thrust.ready),
		.out_valid  (thrust.valid),
		.thrust_cmd (thrust.thrust_cmd),
		.clamped    (thrust.clamped)
	);

	`PTC_ASSERT_NEXT(a_accept_then_integ, clk, arst_n, sample.valid && sample.ready, ctrl.integ_en, "integral step did not follow request")
	`PTC_ASSERT_NOW(a_busy_not_ready, clk, arst_n, ctrl.div_en, !sample.ready, "input ready while dividing")
	`PTC_ASSERT_NOW(a_no_overwrite, clk, arst_n, ctrl.out_load, !(thrust.valid && !thrust.ready), "result overwritten while held")
	`PTC_ASSERT_NOW(a_clamp_value, clk, arst_n, thrust.valid && (thrust.thrust_cmd != '0) && (thrust.thrust_cmd != THRUST_W'(THRUST_LIMIT)), !thrust.clamped, "clamp flag on in-range thrust")

endmodule

### bench/pid_thrust_controller_core_tb.sv
// ----------------------------------------------------------------------------
// pid_thrust_controller_core_tb
// self-checking bench for the pid thrust controller. Speed samples go in over
// the sample channel and registers are set over the apb port. Each thrust
// request is checked against an exact wide-integer prediction of the loop.
// Phases: directed corners, randomised gain and setpoint settings with random
// back-pressure, a steady hard wind-up of the error integral, and a pull-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_thrust_controller_core_tb;
	import ptc_pkg::*;

	localparam int SPEED_BITS = 32;
	localparam int THRUST_LIMIT = 242000;
	localparam int IDLE_PCT = 38;
	localparam int SHOWN_MAX = 40;
	localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint INTEG_MIN = -INTEG_MAX - 1;

	typedef struct packed {
		logic [THRUST_W-1:0] thrust_cmd;
		logic                clamped;
	} thrust_req_t;

	class thrust_predictor;
		logic [TARGET_W-1:0]        target_speed;
		logic signed [GAIN_W-1:0]   gain_p;
		logic signed [GAIN_W-1:0]   gain_i;
		logic signed [GAIN_W-1:0]   gain_d;
		logic [SENS_W-1:0]          sens;
		longint                     integral;
		longint                     prev_err;
		thrust_req_t                thrust_due[$];
		int                         n_samples;
		int                         n_clamped;
		int                         n_fail;

		function new();
			target_speed = RST_TARGET;
			gain_p = RST_GAIN_PROP;
			gain_i = RST_GAIN_INTEG;
			gain_d = RST_GAIN_DERIV;
			sens = RST_SENSITIVITY;
			integral = 0;
			prev_err = 0;
			n_samples = 0;
			n_clamped = 0;
			n_fail = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_TARGET: target_speed = value;
				REG_GAIN_PROP: gain_p = value;
				REG_GAIN_INTEG: gain_i = value;
				REG_GAIN_DERIV: gain_d = value;
				REG_SENSITIVITY: sens = value[SENS_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_speed(logic [SPEED_BITS-1:0] speed);
			longint               err;
			longint               deriv;
			logic signed [127:0]  drive;
			logic signed [127:0]  div;
			logic signed [127:0]  quot;
			thrust_req_t          req;
			err = $signed({32'b0, target_speed}) - $signed({32'b0, speed});
			integral = integral + err;
			if (integral > INTEG_MAX)
				integral = INTEG_MAX;
			else if (integral < INTEG_MIN)
				integral = INTEG_MIN;
			deriv = err - prev_err;
			prev_err = err;
			drive = gain_p * err + gain_i * integral + gain_d * deriv;
			drive = drive >>> FRAC_W;
			div = {112'b0, sens};
			if (sens == '0)
				div = 1;
			if (drive < 0) begin
				// floor then truncate: small negatives give zero unclamped
				req.thrust_cmd = '0;
				req.clamped = (-drive >= div);
			end else begin
				quot = drive / div;
				if (quot > THRUST_LIMIT) begin
					req.thrust_cmd = THRUST_W'(THRUST_LIMIT);
					req.clamped = 1'b1;
				end else begin
					req.thrust_cmd = quot[THRUST_W-1:0];
					req.clamped = 1'b0;
				end
			end
			n_samples++;
			if (req.clamped)
				n_clamped++;
			thrust_due.push_back(req);
		endfunction

		function void mismatch(string field, logic [31:0] want, logic [31:0] got);
			n_fail++;
			if (n_fail <= SHOWN_MAX)
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
		endfunction

		function void check_thrust(logic [THRUST_W-1:0] thrust_cmd, logic clamped);
			thrust_req_t req;
			if (thrust_due.size() == 0) begin
				n_fail++;
				if (n_fail <= SHOWN_MAX)
					$display("%0t: thrust request with none due, expected nothing actual %0d/%0d",
						$time, thrust_cmd, clamped);
				return;
			end
			req = thrust_due.pop_front();
			if (thrust_cmd !== req.thrust_cmd)
				mismatch("thrust_cmd", req.thrust_cmd, thrust_cmd);
			if (clamped !== req.clamped)
				mismatch("clamped", req.clamped, clamped);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	bit                 steady;
	int                 n_settings;

	thrust_predictor pid = new();

	ptc_speed_if #(.SPEED_BITS(SPEED_BITS)) speed_ch ();
	ptc_thrust_if thrust_ch ();

	pid_thrust_controller_core #(
		.SPEED_BITS(SPEED_BITS),
		.THRUST_LIMIT(THRUST_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(speed_ch),
		.thrust(thrust_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("pid_thrust_controller_core_tb NOT OK");
		$finish;
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(7))
			0: g = '0;
			1: g = 32'h7FFF_FFFF;
			2: g = 32'h8000_0000;
			3: g = $urandom;
			default: begin
				g = $urandom_range(32'h0004_0000);
				if ($urandom_range(1))
					g = -g;
			end
		endcase
		return g;
	endfunction

	function automatic logic [PDATA_W-1:0] pick_sens();
		logic [SENS_W-1:0] s;
		case ($urandom_range(6))
			0: s = '0;
			1: s = 16'd1;
			2: s = '1;
			3: s = $urandom_range(1, 64);
			default: s = $urandom_range(1, 65535);
		endcase
		// upper bits are outside the register
		return {16'($urandom), s};
	endfunction

	function automatic logic [SPEED_BITS-1:0] pick_speed(logic [SPEED_BITS-1:0] centre);
		logic [SPEED_BITS-1:0] s;
		logic [SPEED_BITS-1:0] d;
		case ($urandom_range(9))
			0: s = '0;
			1: s = '1;
			2, 3: s = $urandom;
			default: begin
				d = $urandom_range(32'(1) << $urandom_range(24));
				s = $urandom_range(1) ? centre + d : centre - d;
			end
		endcase
		return s;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		pid.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_setting(logic [31:0] target, logic [31:0] kp, logic [31:0] ki,
		logic [31:0] kd, logic [31:0] sens_word);
		write_reg(REG_TARGET, target);
		write_reg(REG_GAIN_PROP, kp);
		write_reg(REG_GAIN_INTEG, ki);
		write_reg(REG_GAIN_DERIV, kd);
		write_reg(REG_SENSITIVITY, sens_word);
		n_settings++;
	endtask

	task automatic send_speed(logic [SPEED_BITS-1:0] speed);
		int gap;
		gap = take_break() ? $urandom_range(1, 40) : 0;
		repeat (gap) begin
			@(negedge clk);
			speed_ch.valid <= 1'b0;
		end
		@(negedge clk);
		speed_ch.valid <= 1'b1;
		speed_ch.measured_speed <= speed;
		@(posedge clk);
		while (!speed_ch.ready) @(posedge clk);
		pid.note_speed(speed);
	endtask

	task automatic end_phase();
		@(negedge clk);
		speed_ch.valid <= 1'b0;
		while (pid.thrust_due.size() != 0) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		logic [31:0] centre;
		if ($urandom_range(3) == 0)
			centre = $urandom_range(1) ? '1 : '0;
		else
			centre = $urandom;
		apply_setting(centre, rand_gain(), rand_gain(), rand_gain(), pick_sens());
		repeat (count) send_speed(pick_speed(centre));
		end_phase();
	endtask

	// thrust side: random stalls
	initial begin
		thrust_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			thrust_ch.ready <= !take_break();
		end
	end

	always @(posedge clk) begin
		if (arst_n && thrust_ch.valid && thrust_ch.ready)
			pid.check_thrust(thrust_ch.thrust_cmd, thrust_ch.clamped);
	end

	initial begin
		logic [31:0] probe[$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		speed_ch.valid = 1'b0;
		speed_ch.measured_speed = '0;
		steady = 1'b0;
		n_settings = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: small negative sum truncates to zero
		probe = {32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'hFFFF_FFFF, 32'd0};
		foreach (probe[i]) send_speed(probe[i]);
		end_phase();

		// zero sensitivity acts as a divisor of one
		apply_setting(32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
		probe = {32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h8000_0001,
			32'h8000_0000};
		foreach (probe[i]) send_speed(probe[i]);
		end_phase();

		// extreme gains and divisor
		apply_setting(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		probe = {32'd0, 32'hFFFF_FFFF, 32'd12345, 32'hFFFF_FFFF, 32'd0};
		foreach (probe[i]) send_speed(probe[i]);
		end_phase();

		for (int ph = 0; ph < 9; ph++) begin
			steady = (ph == 4);
			random_phase(115);
		end

		// wind the integral up with the largest error
		steady = 1'b1;
		apply_setting(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 32'd1);
		repeat (24) send_speed('0);
		end_phase();

		// integral alone visible at the output, then pulled back
		apply_setting(32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0, 32'd65535);
		steady = 1'b0;
		repeat (4) send_speed(32'h8000_0000);
		repeat (4) send_speed(32'h7FFF_FF00);
		repeat (4) send_speed(32'hFFFF_FFFF);
		end_phase();

		repeat (64) @(posedge clk);
		$display("run: %0d speed requests over %0d register settings, %0d thrust requests clamped",
			pid.n_samples, n_settings, pid.n_clamped);
		$display("run: random back-pressure on both channels, integral wound up and pulled back");
		if (pid.n_fail == 0 && pid.thrust_due.size() == 0)
			$display("pid_thrust_controller_core_tb OK");
		else
			$display("pid_thrust_controller_core_tb NOT OK");
		$finish;
	end

endmodule
